// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

    // Ring store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Field widths
    localparam int OP_W   = 3;
    localparam int VAL_W  = 32;
    localparam int CAP_W  = 11;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Stream packing
    localparam int IN_BITS   = OP_W + VAL_W;
    localparam int IN_TW     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = 1 + VAL_W + VAL_W + 1 + 1;
    localparam int OUT_TW    = ((OUT_BITS + 7) / 8) * 8;

    localparam int CAP_RESET = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DONE
    } t_state;

endpackage

// ===== rtl/bounded_deque_core.sv =====
// Channel  | Direction | Payload (tdata, lowest bit first)
// ---------+-----------+-------------------------------------------------------
// s_axis   | in        | operation[2:0], value[34:3], zero pad to 40 bits
// m_axis   | out       | ok[0], front_value[32:1], rear_value[64:33],
//          |           | is_empty[65], is_full[66], zero pad to 72 bits
// cfg      | in        | capacity[10:0], written whenever i_cfg_we is high
//
// One request at a time: accept, execute, optional memory read, result load.
// An insert, a query or a delete that leaves at most one entry goes from execute
// straight to result load; a delete that leaves two or more also passes the memory
// read, as the new front or rear comes from the single-port ring RAM (registered read).
// The result sits in an output register; the next request is taken while it
// waits, and a stalled result only holds the done state of the following one.
// Reset (synchronous, active low) empties the deque, sets capacity to 1024;
// RAM contents are not cleared and need no clearing pass.
module bounded_deque_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [bdq_pkg::IN_TW-1:0]     i_s_axis_tdata,   // operation, value
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [bdq_pkg::OUT_TW-1:0]    o_m_axis_tdata,   // ok, front, rear, empty, full
    input  logic                          i_cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]     i_cfg_wdata        // capacity
);

    localparam int AW  = bdq_pkg::ADDR_W;
    localparam int CW  = bdq_pkg::CNT_W;
    localparam int VW  = bdq_pkg::VAL_W;

    // wrap head+offset (both below DEPTH, sum below 2*DEPTH) into ring range
    function automatic logic [AW-1:0] ring_wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = s;
        if (s >= (CW+1)'(bdq_pkg::DEPTH)) begin
            t = s - (CW+1)'(bdq_pkg::DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // ring RAM
    logic [VW-1:0] mem [bdq_pkg::DEPTH];
    logic [VW-1:0] r_rd_data;

    bdq_pkg::t_state r_state, n_state;

    logic [bdq_pkg::OP_W-1:0]  r_op;
    logic [VW-1:0]             r_val;
    logic [AW-1:0]             r_head;
    logic [CW-1:0]             r_count;
    logic [VW-1:0]             r_front, r_rear;
    logic                      r_rd_front;
    logic                      r_ok;
    logic [bdq_pkg::CAP_W-1:0] r_cap;
    logic                      r_out_valid;
    logic [bdq_pkg::OUT_TW-1:0] r_out_data;

    logic                      in_fire;
    logic                      out_free;
    logic [bdq_pkg::CMP_W-1:0] cap_eff;
    logic                      cur_full, cur_empty;

    // execute-step controls
    logic          c_ok;
    logic [AW-1:0] c_head;
    logic [CW-1:0] c_count;
    logic          c_we;
    logic [AW-1:0] c_waddr;
    logic          c_re;
    logic [AW-1:0] c_raddr;
    logic          c_rd_front;
    logic [VW-1:0] c_front, c_rear;
    logic          c_load_out;

    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // capacity saturated to the ring depth
    always_comb begin
        if (bdq_pkg::CMP_W'(r_cap) > bdq_pkg::CMP_W'(bdq_pkg::DEPTH)) begin
            cap_eff = bdq_pkg::CMP_W'(bdq_pkg::DEPTH);
        end else begin
            cap_eff = bdq_pkg::CMP_W'(r_cap);
        end
    end

    assign cur_full  = bdq_pkg::CMP_W'(r_count) >= cap_eff;
    assign cur_empty = (r_count == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bdq_pkg::S_IDLE: begin
                if (in_fire) n_state = bdq_pkg::S_EXEC;
            end
            bdq_pkg::S_EXEC: begin
                n_state = c_re ? bdq_pkg::S_READ : bdq_pkg::S_DONE;
            end
            bdq_pkg::S_READ: begin
                n_state = bdq_pkg::S_DONE;
            end
            bdq_pkg::S_DONE: begin
                if (out_free) n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and execute decisions
    always_comb begin
        o_s_axis_tready = (r_state == bdq_pkg::S_IDLE);
        c_load_out      = (r_state == bdq_pkg::S_DONE) && out_free;
        c_ok       = 1'b1;
        c_head     = r_head;
        c_count    = r_count;
        c_we       = 1'b0;
        c_waddr    = r_head;
        c_re       = 1'b0;
        c_raddr    = r_head;
        c_rd_front = 1'b0;
        c_front    = r_front;
        c_rear     = r_rear;
        if (r_state == bdq_pkg::S_EXEC) begin
            unique case (r_op)
                bdq_pkg::OP_PUSH_FRONT: begin
                    if (cur_full) begin
                        c_ok = 1'b0;
                    end else begin
                        c_head  = (r_head == '0) ? AW'(bdq_pkg::DEPTH - 1) : r_head - 1'b1;
                        c_we    = 1'b1;
                        c_waddr = c_head;
                        c_count = r_count + 1'b1;
                        c_front = r_val;
                        if (cur_empty) c_rear = r_val;
                    end
                end
                bdq_pkg::OP_PUSH_BACK: begin
                    if (cur_full) begin
                        c_ok = 1'b0;
                    end else begin
                        c_we    = 1'b1;
                        c_waddr = ring_wrap((CW+1)'(r_head) + (CW+1)'(r_count));
                        c_count = r_count + 1'b1;
                        c_rear  = r_val;
                        if (cur_empty) c_front = r_val;
                    end
                end
                bdq_pkg::OP_POP_FRONT: begin
                    if (cur_empty) begin
                        c_ok = 1'b0;
                    end else begin
                        c_head  = (r_head == AW'(bdq_pkg::DEPTH - 1)) ? '0 : r_head + 1'b1;
                        c_count = r_count - 1'b1;
                        if (r_count == CW'(2)) begin
                            c_front = r_rear;       // one left: front is the rear
                        end else if (r_count > CW'(2)) begin
                            c_re       = 1'b1;
                            c_raddr    = c_head;
                            c_rd_front = 1'b1;
                        end
                    end
                end
                bdq_pkg::OP_POP_BACK: begin
                    if (cur_empty) begin
                        c_ok = 1'b0;
                    end else begin
                        c_count = r_count - 1'b1;
                        if (r_count == CW'(2)) begin
                            c_rear = r_front;
                        end else if (r_count > CW'(2)) begin
                            c_re    = 1'b1;
                            c_raddr = ring_wrap((CW+1)'(r_head) + (CW+1)'(r_count)
                                                - (CW+1)'(2));
                        end
                    end
                end
                default: begin
                    // query and unused codes change nothing
                end
            endcase
        end
    end

    // ring RAM, registered read
    always_ff @(posedge i_clk) begin
        if (c_we) mem[c_waddr] <= r_val;
        if (c_re) r_rd_data <= mem[c_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_cap       <= bdq_pkg::CAP_W'(bdq_pkg::CAP_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cap <= i_cfg_wdata;
            if (r_state == bdq_pkg::S_EXEC) begin
                r_head  <= c_head;
                r_count <= c_count;
            end
            if (c_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op  <= i_s_axis_tdata[bdq_pkg::OP_W-1:0];
            r_val <= i_s_axis_tdata[bdq_pkg::OP_W +: VW];
        end
        if (r_state == bdq_pkg::S_EXEC) begin
            r_ok       <= c_ok;
            r_front    <= c_front;
            r_rear     <= c_rear;
            r_rd_front <= c_rd_front;
        end
        if (r_state == bdq_pkg::S_READ) begin
            if (r_rd_front) r_front <= r_rd_data;
            else            r_rear  <= r_rd_data;
        end
        if (c_load_out) begin
            r_out_data <= {{(bdq_pkg::OUT_TW - bdq_pkg::OUT_BITS){1'b0}},
                           cur_full,
                           cur_empty,
                           cur_empty ? {VW{1'b1}} : r_rear,
                           cur_empty ? {VW{1'b1}} : r_front,
                           r_ok};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/bdq_checker.sv =====
module bdq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_axis_tvalid,
    input logic                       o_s_axis_tready,
    input logic                       o_m_axis_tvalid,
    input logic                       i_m_axis_tready,
    input logic [bdq_pkg::OUT_TW-1:0] o_m_axis_tdata
);

    localparam int VW = bdq_pkg::VAL_W;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed under stall");

    // one request in flight: ready drops after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request taken while busy");

    // empty deque reports -1 at both ends
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1 + 2*VW] |->
            (o_m_axis_tdata[1 +: VW] == '1) && (o_m_axis_tdata[1 + VW +: VW] == '1))
        else $error("empty result with live front or rear");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[bdq_pkg::OUT_TW-1:bdq_pkg::OUT_BITS] == '0)
        else $error("result pad bits set");

endmodule

bind bounded_deque_core bdq_checker u_bdq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
